/* src/assert_macros.svh */
// Assertion macros for the checker file (rad_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is low.
`define RAD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RAD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/rad_pkg.sv */
package rad_pkg;

	// Field widths
	localparam int ADDR_W    = 32;
	localparam int TGT_W     = 4;
	localparam int SZ_W      = 4;
	localparam int OP_W      = 2;
	localparam int IDX_OUT_W = 3;

	// Default table depth
	localparam int REGION_COUNT_DEF = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_DEL    = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

endpackage

/* src/region_address_decoder.sv */
// Region address decoder: a table of address regions (base, length, target
// id) that is added to, deleted from and searched by one command beat.
// Command channel: a beat is taken at a rising edge with start high and busy
// low. busy stays low, so a new command may be issued in every cycle.
// operation selects add, delete or lookup; address and region_size give the
// region or the access address; target_id is stored by add; access_size and
// is_write are forwarded on lookup.
// Result channel: each command passes through the input register and then the
// result register, after which done stays high for exactly one cycle, with ok,
// region_index, hit_target, out_access_size and out_is_write valid in that
// cycle, and the result beat is taken at the edge that closes it. The receiver
// cannot stall; results must be taken when done is high.
// Throughput is one command per cycle. Every command is decoded combinationally
// from its input register against all table entries in parallel (one range
// compare per entry plus a priority pick), and the table is written at the
// same edge as the result register, so the next command sees the update.
// Reset (arst_n low) clears the whole table to empty and drops any command
// in flight; no clearing pass is needed afterwards.
module region_address_decoder #(
	parameter int REGION_COUNT = rad_pkg::REGION_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rad_pkg::OP_W-1:0]      operation,
	input  logic [rad_pkg::ADDR_W-1:0]    address,
	input  logic [rad_pkg::ADDR_W-1:0]    region_size,
	input  logic [rad_pkg::TGT_W-1:0]     target_id,
	input  logic [rad_pkg::SZ_W-1:0]      access_size,
	input  logic                          is_write,
	output logic                          done,
	output logic                          ok,
	output logic [rad_pkg::IDX_OUT_W-1:0] region_index,
	output logic [rad_pkg::TGT_W-1:0]     hit_target,
	output logic [rad_pkg::SZ_W-1:0]      out_access_size,
	output logic                          out_is_write
);

	// Input register
	logic                          valid_s1;
	logic [rad_pkg::OP_W-1:0]      op_s1;
	logic [rad_pkg::ADDR_W-1:0]    addr_s1;
	logic [rad_pkg::ADDR_W-1:0]    size_s1;
	logic [rad_pkg::TGT_W-1:0]     tgt_s1;
	logic [rad_pkg::SZ_W-1:0]      asz_s1;
	logic                          wr_s1;

	// Region table
	logic [rad_pkg::ADDR_W-1:0]    base_q [REGION_COUNT];
	logic [rad_pkg::ADDR_W-1:0]    len_q  [REGION_COUNT];
	logic [rad_pkg::TGT_W-1:0]     tgt_q  [REGION_COUNT];

	// Decode results
	logic [rad_pkg::ADDR_W-1:0]    entry_end [REGION_COUNT];
	logic [rad_pkg::ADDR_W-1:0]    req_end;
	logic [REGION_COUNT-1:0]       in_rgn;
	logic [REGION_COUNT-1:0]       overlap;
	logic [REGION_COUNT-1:0]       add_sel;
	logic [REGION_COUNT-1:0]       del_sel;
	logic                          clash;
	logic                          free_found;
	logic                          del_found;
	logic                          hit_found;
	logic [rad_pkg::IDX_OUT_W-1:0] add_idx;
	logic [rad_pkg::IDX_OUT_W-1:0] del_idx;
	logic [rad_pkg::IDX_OUT_W-1:0] hit_idx;
	logic [rad_pkg::TGT_W-1:0]     hit_tgt;
	logic                          do_add;
	logic                          do_del;

	// Next result
	logic                          ok_d;
	logic [rad_pkg::IDX_OUT_W-1:0] idx_d;
	logic [rad_pkg::TGT_W-1:0]     hit_d;
	logic [rad_pkg::SZ_W-1:0]      asz_d;
	logic                          wr_d;

	// Result register
	logic                          done_s2;
	logic                          ok_s2;
	logic [rad_pkg::IDX_OUT_W-1:0] idx_s2;
	logic [rad_pkg::TGT_W-1:0]     hit_s2;
	logic [rad_pkg::SZ_W-1:0]      asz_s2;
	logic                          wr_s2;

	// No command is ever held back, so busy is tied low
	assign busy = 1'b0;

	// Command capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1   <= operation;
			addr_s1 <= address;
			size_s1 <= region_size;
			tgt_s1  <= target_id;
			asz_s1  <= access_size;
			wr_s1   <= is_write;
		end
	end

	// Per-entry range compares, all sums wrap at 32 bits
	assign req_end = addr_s1 + size_s1;

	always_comb begin
		for (int k = 0; k < REGION_COUNT; k++) begin
			entry_end[k] = base_q[k] + len_q[k];
			in_rgn[k]    = (base_q[k] <= addr_s1) && (entry_end[k] > addr_s1);
			overlap[k]   = in_rgn[k] || ((addr_s1 <= base_q[k]) && (req_end > base_q[k]));
		end
	end

	// Priority picks: lowest free slot, lowest delete match, lowest hit
	always_comb begin
		clash      = 1'b0;
		free_found = 1'b0;
		del_found  = 1'b0;
		hit_found  = 1'b0;
		add_sel    = '0;
		del_sel    = '0;
		add_idx    = '0;
		del_idx    = '0;
		hit_idx    = '0;
		hit_tgt    = '0;
		for (int k = 0; k < REGION_COUNT; k++) begin
			if ((len_q[k] != '0) && overlap[k]) begin
				clash = 1'b1;
			end
			if ((len_q[k] == '0) && !free_found) begin
				free_found = 1'b1;
				add_sel[k] = 1'b1;
				add_idx    = rad_pkg::IDX_OUT_W'(k);
			end
			if ((base_q[k] == addr_s1) && (len_q[k] == size_s1) && !del_found) begin
				del_found  = 1'b1;
				del_sel[k] = 1'b1;
				del_idx    = rad_pkg::IDX_OUT_W'(k);
			end
			if (in_rgn[k] && !hit_found) begin
				hit_found = 1'b1;
				hit_idx   = rad_pkg::IDX_OUT_W'(k);
				hit_tgt   = tgt_q[k];
			end
		end
	end

	assign do_add = valid_s1 && (op_s1 == rad_pkg::OP_ADD) && !clash && free_found;
	assign do_del = valid_s1 && (op_s1 == rad_pkg::OP_DEL) && del_found;

	// Result select by operation
	always_comb begin
		ok_d  = 1'b0;
		idx_d = '0;
		hit_d = '0;
		asz_d = '0;
		wr_d  = 1'b0;
		unique case (op_s1)
			rad_pkg::OP_ADD: begin
				ok_d  = !clash && free_found;
				idx_d = (!clash && free_found) ? add_idx : '0;
			end
			rad_pkg::OP_DEL: begin
				ok_d  = del_found;
				idx_d = del_idx;
			end
			rad_pkg::OP_LOOKUP: begin
				ok_d  = hit_found;
				idx_d = hit_idx;
				hit_d = hit_tgt;
				asz_d = asz_s1;
				wr_d  = wr_s1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// Table update, lands together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < REGION_COUNT; k++) begin
				base_q[k] <= '0;
				len_q[k]  <= '0;
				tgt_q[k]  <= '0;
			end
		end else begin
			for (int k = 0; k < REGION_COUNT; k++) begin
				if (do_add && add_sel[k]) begin
					base_q[k] <= addr_s1;
					len_q[k]  <= size_s1;
					tgt_q[k]  <= tgt_s1;
				end else if (do_del && del_sel[k]) begin
					len_q[k] <= '0;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			ok_s2  <= ok_d;
			idx_s2 <= idx_d;
			hit_s2 <= hit_d;
			asz_s2 <= asz_d;
			wr_s2  <= wr_d;
		end
	end

	assign done            = done_s2;
	assign ok              = ok_s2;
	assign region_index    = idx_s2;
	assign hit_target      = hit_s2;
	assign out_access_size = asz_s2;
	assign out_is_write    = wr_s2;

endmodule

/* src/rad_checker.sv */
`include "assert_macros.svh"

module rad_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [rad_pkg::OP_W-1:0]      operation,
	input logic [rad_pkg::SZ_W-1:0]      access_size,
	input logic                          is_write,
	input logic                          done,
	input logic                          ok,
	input logic [rad_pkg::IDX_OUT_W-1:0] region_index,
	input logic [rad_pkg::TGT_W-1:0]     hit_target,
	input logic [rad_pkg::SZ_W-1:0]      out_access_size,
	input logic                          out_is_write
);

	logic cmd_beat;
	logic lookup_beat;

	assign cmd_beat    = start && !busy;
	assign lookup_beat = cmd_beat && (operation == rad_pkg::OP_LOOKUP);

	// One result beat per command beat, after the input and result registers
	`RAD_ASSERT(a_done_follows, cmd_beat |=> ##1 done, "result beat missing after command")
	`RAD_ASSERT(a_no_spurious, (!cmd_beat ##1 1'b1) |=> !done, "result beat without a command")

	// A failed operation reports neither slot nor target
	`RAD_ASSERT(a_fail_zero, (done && !ok) |-> (region_index == '0 && hit_target == '0), "failed beat carries slot or target")

	// Access size and direction pass through only on lookup
	`RAD_ASSERT(a_passthru, lookup_beat |=> ##1 (out_access_size == $past(access_size, 2) && out_is_write == $past(is_write, 2)), "lookup fields not forwarded")

	// No result beat in the cycle after a reset edge
	`RAD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "result beat after reset")

endmodule

bind region_address_decoder rad_checker u_rad_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.operation       (operation),
	.access_size     (access_size),
	.is_write        (is_write),
	.done            (done),
	.ok              (ok),
	.region_index    (region_index),
	.hit_target      (hit_target),
	.out_access_size (out_access_size),
	.out_is_write    (out_is_write)
);

/* tb/sv/tb_region_address_decoder.sv */
module tb_region_address_decoder;
	import rad_pkg::*;

	localparam int SLOTS        = REGION_COUNT_DEF;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_ITEMS  = 470;
	localparam int RECENT_MAX   = 24;
	localparam int REPORT_MAX   = 10;

	// op code 3 is not decoded by the block
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] size;
		logic [TGT_W-1:0]  tgt;
		logic [SZ_W-1:0]   asz;
		logic              wr;
	} decoder_cmd_t;

	typedef struct packed {
		logic                 ok;
		logic [IDX_OUT_W-1:0] idx;
		logic [TGT_W-1:0]     hit;
		logic [SZ_W-1:0]      asz;
		logic                 wr;
	} decode_result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
	} region_span_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [OP_W-1:0]      operation = OP_ADD;
	logic [ADDR_W-1:0]    address = '0;
	logic [ADDR_W-1:0]    region_size = '0;
	logic [TGT_W-1:0]     target_id = '0;
	logic [SZ_W-1:0]      access_size = 4'd1;
	logic                 is_write = 1'b0;
	logic                 busy;
	logic                 done;
	logic                 ok;
	logic [IDX_OUT_W-1:0] region_index;
	logic [TGT_W-1:0]     hit_target;
	logic [SZ_W-1:0]      out_access_size;
	logic                 out_is_write;

	// shadow copy of the region table
	logic [ADDR_W-1:0] table_base [SLOTS];
	logic [ADDR_W-1:0] table_length [SLOTS];
	logic [TGT_W-1:0]  table_target [SLOTS];

	decoder_cmd_t   pending_cmds[$];
	decode_result_t expected_decodes[$];
	region_span_t   recent_regions[$];
	decoder_cmd_t   drv_cmd;

	int send_idle_pct = 18;
	int pushed_beats = 0;
	int accepted_beats = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	region_address_decoder #(
		.REGION_COUNT(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.address(address),
		.region_size(region_size),
		.target_id(target_id),
		.access_size(access_size),
		.is_write(is_write),
		.done(done),
		.ok(ok),
		.region_index(region_index),
		.hit_target(hit_target),
		.out_access_size(out_access_size),
		.out_is_write(out_is_write)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one command to the shadow table and return the result it yields.
	function automatic decode_result_t decode_command(input decoder_cmd_t cmd);
		decode_result_t    res;
		logic              clash;
		logic [ADDR_W-1:0] entry_end;
		logic [ADDR_W-1:0] req_end;
		res = '0;
		clash = 1'b0;
		req_end = cmd.addr + cmd.size;
		case (cmd.op)
			OP_ADD: begin
				// reject any overlap with a live entry, sums wrap at 32 bits
				for (int k = 0; k < SLOTS; k++) begin
					entry_end = table_base[k] + table_length[k];
					if (table_length[k] != 0 &&
					    ((table_base[k] <= cmd.addr && entry_end > cmd.addr) ||
					     (cmd.addr <= table_base[k] && req_end > table_base[k])))
						clash = 1'b1;
				end
				// lowest empty slot; a zero-length add leaves it empty
				if (!clash) begin
					for (int k = 0; k < SLOTS; k++) begin
						if (!res.ok && table_length[k] == 0) begin
							table_base[k] = cmd.addr;
							table_length[k] = cmd.size;
							table_target[k] = cmd.tgt;
							res.ok = 1'b1;
							res.idx = IDX_OUT_W'(k);
						end
					end
				end
			end
			OP_DEL: begin
				// empty slots match too when the stored base agrees
				for (int k = 0; k < SLOTS; k++) begin
					if (!res.ok && table_base[k] == cmd.addr &&
					    table_length[k] == cmd.size) begin
						table_length[k] = '0;
						res.ok = 1'b1;
						res.idx = IDX_OUT_W'(k);
					end
				end
			end
			OP_LOOKUP: begin
				res.asz = cmd.asz;
				res.wr = cmd.wr;
				for (int k = 0; k < SLOTS; k++) begin
					entry_end = table_base[k] + table_length[k];
					if (!res.ok && table_base[k] <= cmd.addr && entry_end > cmd.addr) begin
						res.ok = 1'b1;
						res.idx = IDX_OUT_W'(k);
						res.hit = table_target[k];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Queue one command; remember non-empty regions for later deletes and hits.
	task automatic push_cmd(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
	                        input logic [ADDR_W-1:0] size, input logic [TGT_W-1:0] tgt,
	                        input logic [SZ_W-1:0] asz, input logic wr);
		decoder_cmd_t cmd;
		cmd = '{op: op, addr: addr, size: size, tgt: tgt, asz: asz, wr: wr};
		pending_cmds.push_back(cmd);
		pushed_beats++;
		if (op == OP_ADD && size != 0) begin
			recent_regions.push_back('{base: addr, len: size});
			if (recent_regions.size() > RECENT_MAX)
				void'(recent_regions.pop_front());
		end
	endtask

	// Random command: mostly adds, deletes and lookups aimed at known regions.
	task automatic push_random_cmd();
		int                pick;
		int                slot;
		logic [ADDR_W-1:0] window;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] addr;
		logic [TGT_W-1:0]  tgt;
		logic [SZ_W-1:0]   asz;
		logic              wr;
		region_span_t      span;
		pick = $urandom_range(99);
		tgt = TGT_W'($urandom_range(15));
		asz = SZ_W'($urandom_range(1, 8));
		wr = 1'($urandom_range(1));
		case ($urandom_range(3))
			0: window = 32'h0000_0000;
			1: window = 32'h8000_0000;
			default: window = 32'hFFFF_C000;
		endcase
		base = window + $urandom_range(32'h3FFF);
		case ($urandom_range(19))
			0: len = '0;
			1: len = $urandom();
			default: len = $urandom_range(1, 32'h200);
		endcase
		if (pick < 28) begin
			push_cmd(OP_ADD, base, len, tgt, asz, wr);
		end else if (pick < 52) begin
			if (recent_regions.size() != 0 && $urandom_range(4) != 0) begin
				slot = $urandom_range(recent_regions.size() - 1);
				span = recent_regions[slot];
				recent_regions.delete(slot);
				push_cmd(OP_DEL, span.base, span.len, tgt, asz, wr);
			end else begin
				push_cmd(OP_DEL, base, len, tgt, asz, wr);
			end
		end else if (pick < 97) begin
			if (recent_regions.size() != 0 && $urandom_range(3) != 0) begin
				span = recent_regions[$urandom_range(recent_regions.size() - 1)];
				// inside, just past the end, or just below the base
				case ($urandom_range(5))
					0: addr = span.base + span.len;
					1: addr = span.base - 1;
					default: addr = span.base + ($urandom() % span.len);
				endcase
			end else begin
				addr = $urandom_range(1) ? $urandom() : base;
			end
			push_cmd(OP_LOOKUP, addr, $urandom(), tgt, asz, wr);
		end else begin
			push_cmd(OP_UNUSED, $urandom(), $urandom(), tgt, asz, wr);
		end
	endtask

	task automatic run_random_phase(input int idle_pct, input int count);
		send_idle_pct = idle_pct;
		repeat (count)
			push_random_cmd();
		while (accepted_beats != pushed_beats)
			@(negedge clk);
	endtask

	// Driver: hold a beat while busy, otherwise send the next command or idle.
	always @(posedge clk) begin : drive_commands
		decoder_cmd_t next_cmd;
		if (arst_n) begin
			if (start && !busy) begin
				expected_decodes.push_back(decode_command(drv_cmd));
				accepted_beats <= accepted_beats + 1;
			end
			if (start && busy) begin
				// beat still pending
			end else if (pending_cmds.size() != 0 &&
			             $urandom_range(99) >= send_idle_pct) begin
				next_cmd = pending_cmds.pop_front();
				drv_cmd <= next_cmd;
				start <= 1'b1;
				operation <= next_cmd.op;
				address <= next_cmd.addr;
				region_size <= next_cmd.size;
				target_id <= next_cmd.tgt;
				access_size <= next_cmd.asz;
				is_write <= next_cmd.wr;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every done beat is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		decode_result_t seen;
		decode_result_t want;
		if (arst_n && done) begin
			seen = '{ok: ok, idx: region_index, hit: hit_target,
			         asz: out_access_size, wr: out_is_write};
			if (expected_decodes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: ok=%0d idx=%0d target=%0d size=%0d write=%0d",
					         seen.ok, seen.idx, seen.hit, seen.asz, seen.wr);
			end else begin
				want = expected_decodes.pop_front();
				if (seen.ok !== want.ok || seen.idx !== want.idx || seen.hit !== want.hit ||
				    seen.asz !== want.asz || seen.wr !== want.wr) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("result mismatch: expected ok=%0d idx=%0d target=%0d size=%0d write=%0d, got ok=%0d idx=%0d target=%0d size=%0d write=%0d",
						         want.ok, want.idx, want.hit, want.asz, want.wr,
						         seen.ok, seen.idx, seen.hit, seen.asz, seen.wr);
				end
			end
		end
	end

	// Watchdog: too long without any beat on either side ends the run.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			table_base[k] = '0;
			table_length[k] = '0;
			table_target[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, overlap edges, zero length, wrap, full table
		push_cmd(OP_LOOKUP, 32'h0, 32'h0, 4'h0, 4'd8, 1'b1);
		push_cmd(OP_DEL, 32'h0, 32'h0, 4'h0, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'h1000, 32'h100, 4'hF, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'h10FF, 32'h1, 4'h1, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'h0F00, 32'h101, 4'h2, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'h0F00, 32'h100, 4'h5, 4'd1, 1'b0);
		push_cmd(OP_LOOKUP, 32'h1000, 32'h0, 4'h0, 4'd1, 1'b0);
		push_cmd(OP_LOOKUP, 32'h10FF, 32'hFFFF_FFFF, 4'hF, 4'd4, 1'b1);
		push_cmd(OP_LOOKUP, 32'h1100, 32'h0, 4'h0, 4'd2, 1'b0);
		push_cmd(OP_ADD, 32'h1080, 32'h0, 4'h3, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'h5000, 32'h0, 4'h9, 4'd1, 1'b0);
		push_cmd(OP_ADD, 32'hFFFF_FF00, 32'h200, 4'h7, 4'd1, 1'b0);
		push_cmd(OP_LOOKUP, 32'hFFFF_FFF0, 32'h0, 4'h0, 4'd8, 1'b0);
		push_cmd(OP_LOOKUP, 32'h0000_0010, 32'h0, 4'h0, 4'd1, 1'b1);
		push_cmd(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hA, 4'd1, 1'b0);
		push_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1);
		push_cmd(OP_DEL, 32'h1000, 32'h100, 4'h0, 4'd1, 1'b0);
		push_cmd(OP_DEL, 32'h1000, 32'h100, 4'h0, 4'd1, 1'b0);
		push_cmd(OP_DEL, 32'h0F00, 32'h0FF, 4'h0, 4'd1, 1'b0);
		for (int k = 0; k < 6; k++)
			push_cmd(OP_ADD, 32'h2000_0000 + (k << 12), 32'h80, TGT_W'(k), 4'd1, 1'b0);
		push_cmd(OP_LOOKUP, 32'h2000_1040, 32'h0, 4'h0, 4'd8, 1'b1);

		run_random_phase(18, PHASE_ITEMS);
		run_random_phase(51, PHASE_ITEMS);
		run_random_phase(0, PHASE_ITEMS);

		while (expected_decodes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && expected_decodes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
